FILE: rtl/rmc_pkg.sv
package rmc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [3:0] TAIL_LEN  = 4'd4;

    typedef struct packed {
        logic       sentence_done;
        logic       fix_locked;
        logic [6:0] hour_out;
        logic [6:0] minute_out;
        logic [6:0] second_out;
        logic [6:0] day_out;
        logic [6:0] month_out;
        logic [6:0] year_out;
        logic       capture_valid;
        logic       capture_field;
        logic [3:0] capture_index;
        logic [7:0] capture_char;
    } t_result;

endpackage

FILE: rtl/rmc_parser.sv
module rmc_parser #(
    parameter int CAPTURE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output rmc_pkg::t_result  o_result
);
    import rmc_pkg::*;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_FOUND  = 4'd1;
    localparam logic [3:0] PH_TIME   = 4'd2;
    localparam logic [3:0] PH_STATUS = 4'd3;
    localparam logic [3:0] PH_LAT    = 4'd4;
    localparam logic [3:0] PH_LON    = 4'd5;
    localparam logic [3:0] PH_SPEED  = 4'd6;
    localparam logic [3:0] PH_COURSE = 4'd7;
    localparam logic [3:0] PH_DATE   = 4'd8;
    localparam logic [3:0] PH_VAR    = 4'd9;
    localparam logic [3:0] PH_TAIL   = 4'd10;

    localparam int         IDX_LIM_INT = (CAPTURE_DEPTH - 1 > 15) ? 15 : CAPTURE_DEPTH - 1;
    localparam logic [3:0] IDX_LIMIT   = 4'(IDX_LIM_INT);

    // Digits are held as six BCD digits, so the split into pairs needs no divider.
    logic [3:0]       r_phase, n_phase;
    logic             r_inner, n_inner;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_lock, n_lock;
    logic [5:0][3:0]  r_bcd, n_bcd;
    logic             r_ended, n_ended;
    logic [2:0][6:0]  r_time, n_time;
    logic [2:0][6:0]  r_date, n_date;

    logic             is_comma;
    logic             is_digit;
    logic [3:0]       tail_cnt;
    logic             cap;
    logic             fld;
    logic [3:0]       idx;
    logic             done;
    logic [2:0][6:0]  pairs;

    function automatic logic [6:0] bcd_pair(input logic [3:0] hi, input logic [3:0] lo);
        return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
    endfunction

    assign is_comma = (i_rx_byte == CH_COMMA);
    assign is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign tail_cnt = r_cnt + 4'd1;

    assign pairs[0] = bcd_pair(r_bcd[5], r_bcd[4]);
    assign pairs[1] = bcd_pair(r_bcd[3], r_bcd[2]);
    assign pairs[2] = bcd_pair(r_bcd[1], r_bcd[0]);

    always_comb begin
        n_phase = r_phase;
        n_inner = r_inner;
        n_cnt   = r_cnt;
        n_lock  = r_lock;
        n_bcd   = r_bcd;
        n_ended = r_ended;
        n_time  = r_time;
        n_date  = r_date;
        cap     = 1'b0;
        fld     = 1'b0;
        idx     = 4'd0;
        done    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == CH_DOLLAR) begin
                    n_phase = PH_FOUND;
                end
            end
            PH_FOUND, PH_COURSE: begin
                if (is_comma) begin
                    n_phase = (r_phase == PH_FOUND) ? PH_TIME : PH_DATE;
                    n_bcd   = '0;
                    n_ended = 1'b0;
                end
            end
            PH_TIME, PH_DATE: begin
                if (is_comma) begin
                    n_phase = (r_phase == PH_TIME) ? PH_STATUS : PH_VAR;
                    n_cnt   = 4'd0;
                    n_bcd   = '0;
                    n_ended = 1'b0;
                    if (r_phase == PH_TIME) begin
                        n_time = pairs;
                    end else begin
                        n_date = pairs;
                    end
                end else if (!r_ended && is_digit) begin
                    // A sixth digit already present means the next one would pass 999999.
                    n_bcd = (r_bcd[5] != 4'd0) ? {6{4'd9}} : {r_bcd[4:0], i_rx_byte[3:0]};
                end else begin
                    n_ended = 1'b1;
                end
            end
            PH_STATUS: begin
                if (is_comma && r_lock) begin
                    n_phase = PH_LAT;
                end else if (i_rx_byte == CH_A) begin
                    n_lock = 1'b1;
                end else begin
                    n_lock  = 1'b0;
                    n_phase = PH_IDLE;
                end
            end
            PH_LAT, PH_LON: begin
                if (is_comma && r_inner) begin
                    n_phase = (r_phase == PH_LAT) ? PH_LON : PH_SPEED;
                    n_inner = 1'b0;
                    n_cnt   = 4'd0;
                end else begin
                    if (is_comma) begin
                        n_inner = 1'b1;
                    end
                    cap = 1'b1;
                    fld = (r_phase == PH_LON);
                    idx = r_cnt;
                    if (r_cnt < IDX_LIMIT) begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            PH_SPEED: begin
                if (is_comma) begin
                    n_phase = PH_COURSE;
                end
            end
            PH_VAR: begin
                if (is_comma) begin
                    n_phase = PH_TAIL;
                    n_cnt   = 4'd0;
                end
            end
            PH_TAIL: begin
                if (tail_cnt >= TAIL_LEN) begin
                    n_phase = PH_IDLE;
                    n_cnt   = 4'd0;
                    done    = 1'b1;
                end else begin
                    n_cnt = tail_cnt;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.sentence_done = done;
        o_result.fix_locked    = n_lock;
        o_result.hour_out      = n_time[0];
        o_result.minute_out    = n_time[1];
        o_result.second_out    = n_time[2];
        o_result.day_out       = n_date[0];
        o_result.month_out     = n_date[1];
        o_result.year_out      = n_date[2];
        o_result.capture_valid = cap;
        o_result.capture_field = fld;
        o_result.capture_index = idx;
        o_result.capture_char  = cap ? i_rx_byte : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_inner <= 1'b0;
            r_cnt   <= 4'd0;
            r_lock  <= 1'b0;
            r_bcd   <= '0;
            r_ended <= 1'b0;
            r_time  <= '0;
            r_date  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_inner <= n_inner;
            r_cnt   <= n_cnt;
            r_lock  <= n_lock;
            r_bcd   <= n_bcd;
            r_ended <= n_ended;
            r_time  <= n_time;
            r_date  <= n_date;
        end
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.sentence_done) |=> (r_phase == PH_IDLE && r_cnt == 4'd0))
        else $error("sentence end did not return the parser to idle");

    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LAT || r_phase == PH_LON) |-> (r_cnt <= IDX_LIMIT))
        else $error("capture index ran past its limit");

    a_unlock_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_STATUS && i_rx_byte != CH_A && !(is_comma && r_lock))
        |=> (!r_lock && r_phase == PH_IDLE))
        else $error("bad status character did not unlock and go idle");

    a_inner_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.capture_valid && is_comma) |=> r_inner)
        else $error("captured inner comma was not recorded");

endmodule

FILE: rtl/rmc_skid.sv
module rmc_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rmc_pkg::t_result  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output rmc_pkg::t_result  o_data
);
    import rmc_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    push;
    logic    pop;

    assign o_stall = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // The skid entry is older than any new transaction, so it moves up first.
    always_ff @(posedge i_clk) begin
        if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (push) begin
                r_main <= i_data;
            end
        end else if (push) begin
            r_skid <= i_data;
        end
    end

endmodule

FILE: rtl/nmea_rmc_time_date_parser.sv
// RMC sentence time/date parser.
// Input channel: one received character per transaction on i_rx_byte, qualified by
// i_valid and held off by o_stall. Output channel: one result per input character on
// o_valid, held off by i_stall. Every accepted character gives exactly one result.
// Each result carries the sentence-done pulse, the current lock flag, the last decoded
// time and date pairs, and, for latitude and longitude characters, the captured byte
// with its field and saturating index.
// Each result is registered into the output buffer, via the skid entry if the receiver
// stalls. Throughput is one character per cycle while o_stall is low; the parser state
// is a single register stage updated by one pass of combinational logic per character.
// A two-entry output buffer lets the input keep flowing while a result waits; when the
// receiver stalls, up to two results are held and then o_stall rises until one drains.
// Synchronous reset returns the parser to idle, clears the lock flag, the digit
// accumulator and the time and date pairs, and empties the output buffer.
module nmea_rmc_time_date_parser #(
    parameter int CAPTURE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_sentence_done,
    output logic       o_fix_locked,
    output logic [6:0] o_hour_out,
    output logic [6:0] o_minute_out,
    output logic [6:0] o_second_out,
    output logic [6:0] o_day_out,
    output logic [6:0] o_month_out,
    output logic [6:0] o_year_out,
    output logic       o_capture_valid,
    output logic       o_capture_field,
    output logic [3:0] o_capture_index,
    output logic [7:0] o_capture_char
);
    import rmc_pkg::*;

    logic    accept;
    t_result result;
    t_result out_data;

    assign accept = i_valid && !o_stall;

    rmc_parser #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_result  (result)
    );

    rmc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (result),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_sentence_done = out_data.sentence_done;
    assign o_fix_locked    = out_data.fix_locked;
    assign o_hour_out      = out_data.hour_out;
    assign o_minute_out    = out_data.minute_out;
    assign o_second_out    = out_data.second_out;
    assign o_day_out       = out_data.day_out;
    assign o_month_out     = out_data.month_out;
    assign o_year_out      = out_data.year_out;
    assign o_capture_valid = out_data.capture_valid;
    assign o_capture_field = out_data.capture_field;
    assign o_capture_index = out_data.capture_index;
    assign o_capture_char  = out_data.capture_char;

endmodule
